@@ rtl/core/cc20_pkg.sv @@
// Shared constants, types and helpers for the ChaCha20 keystream XOR block.
// No dependencies.
package cc20_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY45 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY67 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START = 3'd6;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [15:0][31:0] words_t;

  // queue entry: classified beat
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } qent_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // one quarter round on four words
  function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c, input logic [31:0] d);
    logic [31:0] ta, tb, tc, td;
    ta = a + b; td = rotl(d ^ ta, 16);
    tc = c + td; tb = rotl(b ^ tc, 12);
    ta = ta + tb; td = rotl(td ^ ta, 8);
    tc = tc + td; tb = rotl(tb ^ tc, 7);
    qr = {ta, tb, tc, td};
  endfunction

endpackage

@@ rtl/core/cc20_front.sv @@
// Front end: accepts beats and pushes them into a short queue.
// Depends on cc20_pkg.
module cc20_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            command,
  input  logic [7:0]      data_in,
  output logic            q_valid,
  input  logic            q_pop,
  output cc20_pkg::qent_t q_head
);
  localparam int AW = $clog2(cc20_pkg::QUEUE_DEPTH);

  cc20_pkg::qent_t mem [cc20_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic push, pop;

  assign in_ready = (count != (AW+1)'(cc20_pkg::QUEUE_DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (count != '0);
  assign pop = q_pop && q_valid;
  assign q_head = mem[rptr];

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr].restart <= (command == cc20_pkg::CMD_RESTART);
      mem[wptr].data <= data_in;
    end
  end
endmodule

@@ rtl/core/cc20_core.sv @@
// ChaCha20 block unit: one round a cycle (column, then diagonal), then feed-forward add.
// Depends on cc20_pkg.
module cc20_core #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cc20_pkg::words_t base,
  output logic             busy,
  output logic             done,
  output cc20_pkg::words_t ks
);
  localparam int CW = $clog2(2*DOUBLE_ROUNDS + 1);
  cc20_pkg::words_t w, col, dia;
  logic [CW-1:0] rnd;
  logic          add_stage;

  // column round and diagonal round, both from the current words
  always_comb begin
    col = w;
    for (int i = 0; i < 4; i++)
      {col[i], col[4+i], col[8+i], col[12+i]} = cc20_pkg::qr(w[i], w[4+i], w[8+i], w[12+i]);
    dia = w;
    for (int i = 0; i < 4; i++)
      {dia[i], dia[4+(i+1)%4], dia[8+(i+2)%4], dia[12+(i+3)%4]} =
        cc20_pkg::qr(w[i], w[4+(i+1)%4], w[8+(i+2)%4], w[12+(i+3)%4]);
  end

  // round sequencing: even steps column, odd steps diagonal
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      add_stage <= 1'b0;
      rnd <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        rnd <= '0;
      end else if (busy && !add_stage) begin
        rnd <= rnd + 1'b1;
        if (rnd == CW'(2*DOUBLE_ROUNDS - 1)) add_stage <= 1'b1;
      end else if (add_stage) begin
        add_stage <= 1'b0;
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) w <= base;
    else if (busy && !add_stage) w <= rnd[0] ? dia : col;
    if (add_stage)
      for (int i = 0; i < 16; i++) ks[i] <= w[i] + base[i];
  end
endmodule

@@ rtl/core/cc20_back.sv @@
// Back end: pops queued beats, holds stream state, XORs keystream bytes.
// Depends on cc20_pkg and cc20_core.
module cc20_back #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  cc20_pkg::qent_t                q_head,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     data_out
);
  logic [3:0][63:0] reg_key;
  logic [63:0] reg_nonce01, reg_start;
  logic [31:0] reg_nonce2;
  logic [3:0][63:0] lat_key;
  logic [31:0] lat_n1, lat_n2;
  logic [31:0] ctr_lo, ctr_hi;
  logic [6:0]  pos;
  cc20_pkg::words_t base, ks;
  logic core_start, core_busy, core_done, ks_ok;
  logic out_free, need_blk;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_key <= '0; reg_nonce01 <= '0; reg_nonce2 <= '0; reg_start <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        cc20_pkg::REG_KEY01:   reg_key[0] <= cfg_data;
        cc20_pkg::REG_KEY23:   reg_key[1] <= cfg_data;
        cc20_pkg::REG_KEY45:   reg_key[2] <= cfg_data;
        cc20_pkg::REG_KEY67:   reg_key[3] <= cfg_data;
        cc20_pkg::REG_NONCE01: reg_nonce01 <= cfg_data;
        cc20_pkg::REG_NONCE2:  reg_nonce2 <= cfg_data[31:0];
        cc20_pkg::REG_START:   reg_start <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    base[0] = cc20_pkg::SIGMA0; base[1] = cc20_pkg::SIGMA1;
    base[2] = cc20_pkg::SIGMA2; base[3] = cc20_pkg::SIGMA3;
    for (int i = 0; i < 4; i++) begin
      base[4+2*i] = lat_key[i][31:0];
      base[5+2*i] = lat_key[i][63:32];
    end
    base[12] = ctr_lo; base[13] = ctr_hi; base[14] = lat_n1; base[15] = lat_n2;
  end

  assign out_free = !out_valid || out_ready;
  assign need_blk = pos[6];
  assign q_pop = q_valid && (q_head.restart || (!need_blk && ks_ok && out_free));
  // no new block in the cycle the finished one is handed over
  assign core_start = q_valid && !q_head.restart && need_blk && !core_busy && !core_done &&
                      !ks_ok;

  cc20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk(clk), .rst(rst), .start(core_start), .base(base),
    .busy(core_busy), .done(core_done), .ks(ks)
  );

  // stream state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_key <= '0; lat_n1 <= '0; lat_n2 <= '0;
      ctr_lo <= '0; ctr_hi <= '0;
      pos <= 7'd64; ks_ok <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (core_done) begin
        ks_ok <= 1'b1;
        pos <= 7'd0;
        ctr_lo <= ctr_lo + 32'd1;
        if (ctr_lo == 32'hFFFFFFFF) ctr_hi <= ctr_hi + 32'd1;
      end
      if (q_pop && q_head.restart) begin
        lat_key <= reg_key;
        lat_n1 <= reg_nonce01[63:32];
        lat_n2 <= reg_nonce2;
        ctr_lo <= reg_start[31:0];
        ctr_hi <= reg_nonce01[31:0] + reg_start[63:32];
        pos <= 7'd64;
        ks_ok <= 1'b0;
      end else if (q_pop) begin
        out_valid <= 1'b1;
        pos <= pos + 7'd1;
        if (pos[5:0] == 6'd63) ks_ok <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_head.restart)
      data_out <= q_head.data ^ 8'(ks[pos[5:2]] >> {pos[1:0], 3'b000});
  end
endmodule

@@ rtl/core/chacha20_keystream_xor_top.sv @@
// ChaCha20 keystream XOR block: one byte per beat.
// Sends input beats through a small queue; the back end owns the cipher state.
//
// Input channel in_valid/in_ready carries command and data_in. A restart
// command (1) latches key, nonce and start counter from the registers and
// gives no output; a data command (0) returns data_in XOR the next keystream
// byte on out_valid/out_ready.
// Throughput: one byte a cycle inside a block while the receiver keeps up. At
// each 64-byte boundary the block unit runs 2*DOUBLE_ROUNDS rounds, one a
// cycle, then the feed-forward add, and hands the block over before the first
// byte of the block goes out.
// Path: each data beat is registered in the queue, then in the output register.
// Reset: all registers zero, stream as after a restart with zero key.
// A stalled receiver holds the output register; the queue then fills and
// in_ready falls. Registers are written through cfg_we/cfg_idx/cfg_data
// and take effect at the next restart.
module chacha20_keystream_xor_top #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [7:0]                      data_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      data_out
);
  logic q_valid, q_pop;
  cc20_pkg::qent_t q_head;

  cc20_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .data_in(data_in),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  cc20_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .out_valid(out_valid), .out_ready(out_ready), .data_out(data_out)
  );
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for chacha20_keystream_xor_top: predicts each output byte
// with an independent ChaCha20 block model. Depends on cc20_pkg and the RTL top.
module tb;

  localparam int DR = cc20_pkg::DOUBLE_ROUNDS_DEF;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = cc20_pkg::CMD_DATA;
  logic [7:0]  data_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  data_out;

  chacha20_keystream_xor_top DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: registers, latched stream and current block
  logic [63:0] key_reg [4];
  logic [63:0] nonce01_reg, start_reg;
  logic [31:0] nonce2_reg;
  logic [31:0] base_w [16];
  logic [31:0] ctr_lo, ctr_hi;
  logic [31:0] ks_w [16];
  int unsigned pos;

  beat_t       pending_q[$];
  logic [7:0]  expected_bytes[$];
  int          fail_count = 0;
  bit          quiet_in = 0, quiet_out = 0;
  int          hold_cycles = 0;

  task automatic report(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic logic [31:0] rl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic quarter(inout logic [31:0] w[16], input int a, b, c, d);
    w[a] += w[b]; w[d] = rl(w[d] ^ w[a], 16);
    w[c] += w[d]; w[b] = rl(w[b] ^ w[c], 12);
    w[a] += w[b]; w[d] = rl(w[d] ^ w[a], 8);
    w[c] += w[d]; w[b] = rl(w[b] ^ w[c], 7);
  endtask

  task automatic latch_stream();
    base_w[0] = cc20_pkg::SIGMA0; base_w[1] = cc20_pkg::SIGMA1;
    base_w[2] = cc20_pkg::SIGMA2; base_w[3] = cc20_pkg::SIGMA3;
    for (int i = 0; i < 4; i++) begin
      base_w[4+2*i] = key_reg[i][31:0];
      base_w[5+2*i] = key_reg[i][63:32];
    end
    ctr_lo = start_reg[31:0];
    ctr_hi = nonce01_reg[31:0] + start_reg[63:32];
    base_w[14] = nonce01_reg[63:32];
    base_w[15] = nonce2_reg;
    pos = 64;
  endtask

  task automatic build_block();
    logic [31:0] b[16];
    b = base_w;
    b[12] = ctr_lo;
    b[13] = ctr_hi;
    ks_w = b;
    for (int r = 0; r < DR; r++) begin
      quarter(ks_w, 0, 4, 8, 12);  quarter(ks_w, 1, 5, 9, 13);
      quarter(ks_w, 2, 6, 10, 14); quarter(ks_w, 3, 7, 11, 15);
      quarter(ks_w, 0, 5, 10, 15); quarter(ks_w, 1, 6, 11, 12);
      quarter(ks_w, 2, 7, 8, 13);  quarter(ks_w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_w[i] += b[i];
    ctr_lo++;
    if (ctr_lo == 0) ctr_hi++;
  endtask

  task automatic predict(input beat_t bt);
    logic [31:0] w;
    if (bt.cmd == cc20_pkg::CMD_RESTART) begin
      latch_stream();
      return;
    end
    if (pos >= 64) begin
      build_block();
      pos = 0;
    end
    w = ks_w[pos >> 2];
    expected_bytes.push_back(bt.data ^ w[(pos % 4)*8 +: 8]);
    pos++;
  endtask

  // driver: offer the oldest pending beat; random gaps outside quiet stretches
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict(pending_q.pop_front());
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && (quiet_in || $urandom_range(99) >= 24)) begin
          in_valid <= 1'b1;
          command  <= pending_q[0].cmd;
          data_in  <= pending_q[0].data;
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) report("output beat with nothing expected");
        else begin
          logic [7:0] e;
          e = expected_bytes.pop_front();
          if (data_out !== e)
            report($sformatf("data_out %02h expected %02h", data_out, e));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else out_ready <= quiet_out || ($urandom_range(99) >= 24);
    end
  end

  task automatic cfg_write(input logic [cc20_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cc20_pkg::REG_KEY01:   key_reg[0] = v;
      cc20_pkg::REG_KEY23:   key_reg[1] = v;
      cc20_pkg::REG_KEY45:   key_reg[2] = v;
      cc20_pkg::REG_KEY67:   key_reg[3] = v;
      cc20_pkg::REG_NONCE01: nonce01_reg = v;
      cc20_pkg::REG_NONCE2:  nonce2_reg = v[31:0];
      cc20_pkg::REG_START:   start_reg = v;
      default: ;
    endcase
  endtask

  task automatic queue_beat(input logic c, input logic [7:0] d);
    beat_t b;
    b.cmd = c; b.data = d;
    pending_q.push_back(b);
  endtask

  // wait until every queued beat is taken and every byte has come back
  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_bytes.size() > 0) @(posedge clk);
    repeat (2*DR + 10) @(posedge clk);
  endtask

  task automatic run_phase(input int n);
    queue_beat(cc20_pkg::CMD_RESTART, 8'($urandom));
    for (int i = 0; i < n; i++)
      queue_beat(($urandom_range(99) < 3) ? cc20_pkg::CMD_RESTART : cc20_pkg::CMD_DATA,
                 8'($urandom));
    drain();
  endtask

  task automatic cfg_all(input logic [63:0] k0, k1, k2, k3, n01, input logic [31:0] n2,
                         input logic [63:0] st);
    cfg_write(cc20_pkg::REG_KEY01, k0); cfg_write(cc20_pkg::REG_KEY23, k1);
    cfg_write(cc20_pkg::REG_KEY45, k2); cfg_write(cc20_pkg::REG_KEY67, k3);
    cfg_write(cc20_pkg::REG_NONCE01, n01); cfg_write(cc20_pkg::REG_NONCE2, {32'h0, n2});
    cfg_write(cc20_pkg::REG_START, st);
  endtask

  initial begin
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    nonce01_reg = '0; nonce2_reg = '0; start_reg = '0;
    foreach (ks_w[i]) ks_w[i] = '0;
    latch_stream();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: data before restart, data extremes, restart mid-block
    queue_beat(cc20_pkg::CMD_DATA, 8'h00); queue_beat(cc20_pkg::CMD_DATA, 8'hFF);
    queue_beat(cc20_pkg::CMD_DATA, 8'hA5); queue_beat(cc20_pkg::CMD_DATA, 8'h5A);
    queue_beat(cc20_pkg::CMD_RESTART, 8'hFF);
    for (int i = 0; i < 8; i++) queue_beat(cc20_pkg::CMD_DATA, i[0] ? 8'hFF : 8'h00);
    queue_beat(cc20_pkg::CMD_RESTART, 8'h00);
    queue_beat(cc20_pkg::CMD_RESTART, 8'h00);
    for (int i = 0; i < 6; i++) queue_beat(cc20_pkg::CMD_DATA, 8'($urandom));
    drain();

    // all-ones config: counter low word wraps and carries into the high word
    cfg_all('1, '1, '1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    run_phase(200);

    // long receiver hold-off with the sender busy
    cfg_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
            {$urandom, $urandom}, {$urandom, $urandom}, $urandom, {32'h0, 32'hFFFF_FFFF});
    quiet_in = 1;
    hold_cycles = 300;
    run_phase(150);
    quiet_in = 0;

    // stretch with no idling either side
    cfg_all('0, '0, '0, '0, '0, '0, '0);
    quiet_in = 1; quiet_out = 1;
    run_phase(150);
    quiet_in = 0; quiet_out = 0;

    for (int p = 0; p < 3; p++) begin
      cfg_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
              {$urandom, $urandom});
      run_phase(110);
    end

    if (fail_count == 0) $display("chacha20_keystream_xor_top verification clean");
    else $display("chacha20_keystream_xor_top verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("chacha20_keystream_xor_top verification failed");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/cc20_pkg.sv
rtl/core/cc20_front.sv
rtl/core/cc20_core.sv
rtl/core/cc20_back.sv
rtl/core/chacha20_keystream_xor_top.sv
verif/tb.sv
